@@ rtl/bpcm_pkg.sv @@
// Package for the battery pack cell monitor.
// Holds field widths, command and register codes, controller states and the
// command, status and report structs shared by the RTL files.
package bpcm_pkg;

   // Default sizes of the scan.
   localparam int MAX_MODULES_DEFAULT      = 16;
   localparam int CELLS_PER_MODULE_DEFAULT = 12;

   // Field and register widths.
   localparam int SAMPLE_W  = 17;
   localparam int CELL_W    = 16;
   localparam int MSUM_W    = 20;
   localparam int PSUM_W    = 24;
   localparam int TEMP_W    = 16;
   localparam int TLIM_W    = 12;
   localparam int PS_W      = 5;
   localparam int NS_W      = 8;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int COUNT_W   = 5;
   localparam int SOC_W     = 7;
   localparam int FLAG_W    = 4;

   // Shared divider sizes.
   localparam int DIV_N_W = 32;
   localparam int DIV_D_W = 24;

   // Item commands.
   localparam logic [1:0] CMD_CELL   = 2'd0;
   localparam logic [1:0] CMD_TEMP   = 2'd1;
   localparam logic [1:0] CMD_MODULE = 2'd2;
   localparam logic [1:0] CMD_SCAN   = 2'd3;

   // Report kinds.
   localparam logic KIND_MODULE = 1'b0;
   localparam logic KIND_PACK   = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_VOLTAGE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_VOLTAGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_TEMP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDER_TEMP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PARALLEL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SOC_LOW       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SOC_HIGH      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES        = 3'd7;

   // Register reset values.
   localparam logic [CELL_W-1:0]        RST_OVER_VOLTAGE  = 16'd4200;
   localparam logic [CELL_W-1:0]        RST_UNDER_VOLTAGE = 16'd3000;
   localparam logic signed [TLIM_W-1:0] RST_OVER_TEMP     = 12'sd550;
   localparam logic signed [TLIM_W-1:0] RST_UNDER_TEMP    = 12'sd0;
   localparam logic [PS_W-1:0]          RST_PARALLEL      = 5'd1;
   localparam logic [CELL_W-1:0]        RST_SOC_LOW       = 16'd3200;
   localparam logic [CELL_W-1:0]        RST_SOC_HIGH      = 16'd4100;
   localparam logic [NS_W-1:0]          RST_SERIES        = 8'd96;

   // Flag bit positions.
   localparam int FLAG_OV = 0;
   localparam int FLAG_UV = 1;
   localparam int FLAG_OT = 2;
   localparam int FLAG_UT = 3;

   // Arithmetic constants.
   localparam logic [CELL_W-1:0] CELL_FLOOR_MV = 16'd100;
   localparam logic [SOC_W-1:0]  PCT_SCALE     = 7'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PV_WAIT,
      ST_MUL1,
      ST_MUL2,
      ST_SUB,
      ST_SOC_CHK,
      ST_SOC_WAIT,
      ST_PACK_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic exec_cell;
      logic exec_temp;
      logic module_close;
      logic module_drop;
      logic pv_start;
      logic pv_take;
      logic mul1;
      logic mul2;
      logic sub;
      logic soc_start;
      logic soc_take;
      logic soc_zero;
      logic pack_close;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] cmd;
      logic       pack_full;
      logic       out_free;
      logic       div_busy;
      logic       soc_go;
   } ctrl_sts_type;

   // One report beat.
   typedef struct packed {
      logic                report_kind;
      logic [PSUM_W-1:0]   voltage_mv;
      logic [CELL_W-1:0]   low_cell_mv;
      logic [CELL_W-1:0]   high_cell_mv;
      logic                over_voltage;
      logic                under_voltage;
      logic                over_temp;
      logic                under_temp;
      logic [COUNT_W-1:0]  module_count;
      logic [SOC_W-1:0]    soc_percent;
      logic [PSUM_W-1:0]   lowest_pack_mv;
      logic [PSUM_W-1:0]   highest_pack_mv;
   } rsp_data_type;

endpackage

@@ rtl/bpcm_req_if.sv @@
// Input channel of the battery pack cell monitor: valid, ready and one item.
// Depends on bpcm_pkg for the field widths.
interface bpcm_req_if import bpcm_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 cmd;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink (input valid, input cmd, input sample, output ready);
endinterface

@@ rtl/bpcm_rsp_if.sv @@
// Report channel of the battery pack cell monitor: valid, ready and one report.
// Depends on bpcm_pkg for the field widths.
interface bpcm_rsp_if import bpcm_pkg::*;;
   logic                valid;
   logic                ready;
   logic                report_kind;
   logic [PSUM_W-1:0]   voltage_mv;
   logic [CELL_W-1:0]   low_cell_mv;
   logic [CELL_W-1:0]   high_cell_mv;
   logic                over_voltage;
   logic                under_voltage;
   logic                over_temp;
   logic                under_temp;
   logic [COUNT_W-1:0]  module_count;
   logic [SOC_W-1:0]    soc_percent;
   logic [PSUM_W-1:0]   lowest_pack_mv;
   logic [PSUM_W-1:0]   highest_pack_mv;

   modport source (
      output valid, output report_kind, output voltage_mv, output low_cell_mv,
      output high_cell_mv, output over_voltage, output under_voltage,
      output over_temp, output under_temp, output module_count,
      output soc_percent, output lowest_pack_mv, output highest_pack_mv,
      input ready
   );
   modport sink (
      input valid, input report_kind, input voltage_mv, input low_cell_mv,
      input high_cell_mv, input over_voltage, input under_voltage,
      input over_temp, input under_temp, input module_count,
      input soc_percent, input lowest_pack_mv, input highest_pack_mv,
      output ready
   );
endinterface

@@ rtl/battery_pack_cell_monitor_unit.sv @@
// Battery pack cell monitor, top level.
// The req channel carries one item per beat: a cell voltage, a module
// temperature, a module-done mark or a scan-done mark. The rsp channel carries
// one report per beat: a module report on module done while fewer than
// MAX_MODULES modules are counted, a pack report on scan done; other items
// give no beat. The csr port writes one setting per cycle; the user must write
// only while the block is idle, which the block does not enforce. There is no
// read-back. An item is taken in one cycle and worked in the next, and no new
// item is taken until the last is through. Scan done runs the pack voltage and
// the charge figure through one shared divider, a quotient bit a cycle over
// 32 bits each.
// Reports wait in an output register: the block keeps taking cell and
// temperature beats while the receiver stalls, and holds a done item only
// when a second report has nowhere to go.
// Synchronous reset restores the default settings, clears the module and
// pack accumulators and the lifetime extremes, and drops any waiting report.
// Depends on bpcm_pkg, the channel interfaces, bpcm_ctrl and bpcm_dp.
module battery_pack_cell_monitor_unit import bpcm_pkg::*; #(
   parameter int MAX_MODULES      = MAX_MODULES_DEFAULT,
   parameter int CELLS_PER_MODULE = CELLS_PER_MODULE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   bpcm_req_if.sink             req_chan,
   bpcm_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   rsp_data_type rsp_data;
   logic         rsp_valid;

   bpcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bpcm_dp #(
      .MAX_MODULES      (MAX_MODULES),
      .CELLS_PER_MODULE (CELLS_PER_MODULE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_cmd    (req_chan.cmd),
      .req_sample (req_chan.sample),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_data   (rsp_data)
   );

   // Report beat onto the rsp channel.
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.report_kind     = rsp_data.report_kind;
   assign rsp_chan.voltage_mv      = rsp_data.voltage_mv;
   assign rsp_chan.low_cell_mv     = rsp_data.low_cell_mv;
   assign rsp_chan.high_cell_mv    = rsp_data.high_cell_mv;
   assign rsp_chan.over_voltage    = rsp_data.over_voltage;
   assign rsp_chan.under_voltage   = rsp_data.under_voltage;
   assign rsp_chan.over_temp       = rsp_data.over_temp;
   assign rsp_chan.under_temp      = rsp_data.under_temp;
   assign rsp_chan.module_count    = rsp_data.module_count;
   assign rsp_chan.soc_percent     = rsp_data.soc_percent;
   assign rsp_chan.lowest_pack_mv  = rsp_data.lowest_pack_mv;
   assign rsp_chan.highest_pack_mv = rsp_data.highest_pack_mv;

endmodule

@@ rtl/bpcm_div.sv @@
// Restoring divider of the pack monitor, one quotient bit per cycle.
// Depends on bpcm_pkg for the dividend and divisor widths.
module bpcm_div import bpcm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               busy,
   output logic [DIV_N_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] dsr_ff, dsr_in;
   logic [DIV_D_W:0]   rem_shift;
   logic               take;

   // The partial remainder stays below the divisor, so one extra bit holds the shift.
   assign rem_shift = {rem_ff, quo_ff[DIV_N_W-1]};
   assign take      = rem_shift >= {1'b0, dsr_ff};

   // One shift and subtract step per cycle while busy.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_N_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_N_W-2:0], take};
         rem_in  = take ? DIV_D_W'(rem_shift - {1'b0, dsr_ff}) : rem_shift[DIV_D_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/bpcm_dp.sv @@
// Datapath of the pack monitor: item register, settings, module and pack
// accumulators, charge arithmetic, the shared divider and the report register.
// Depends on bpcm_pkg and bpcm_div.
module bpcm_dp import bpcm_pkg::*; #(
   parameter int MAX_MODULES      = MAX_MODULES_DEFAULT,
   parameter int CELLS_PER_MODULE = CELLS_PER_MODULE_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   output ctrl_sts_type               sts,
   input  logic [1:0]                 req_cmd,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_data_type               rsp_data
);
   localparam int MS_W = $clog2(MAX_MODULES + 1);
   localparam int CC_W = $clog2(CELLS_PER_MODULE + 1);

   typedef struct packed {
      logic [CELL_W-1:0]        ov;
      logic [CELL_W-1:0]        uv;
      logic signed [TLIM_W-1:0] ot;
      logic signed [TLIM_W-1:0] ut;
      logic [PS_W-1:0]          ps;
      logic [CELL_W-1:0]        soclo;
      logic [CELL_W-1:0]        sochi;
      logic [NS_W-1:0]          ns;
   } cfg_type;

   typedef struct packed {
      logic [MSUM_W-1:0]        sum;
      logic [CELL_W-1:0]        low;
      logic [CELL_W-1:0]        high;
      logic signed [TEMP_W-1:0] temp_hi;
      logic signed [TEMP_W-1:0] temp_lo;
      logic [FLAG_W-1:0]        flags;
      logic [CC_W-1:0]          cells;
   } mod_type;

   typedef struct packed {
      logic [PSUM_W-1:0] sum;
      logic [CELL_W-1:0] low;
      logic [CELL_W-1:0] high;
      logic [FLAG_W-1:0] flags;
      logic [MS_W-1:0]   seen;
      logic [PSUM_W-1:0] lowest;
      logic [PSUM_W-1:0] highest;
   } pack_type;

   localparam cfg_type CFG_RESET = '{
      ov: RST_OVER_VOLTAGE, uv: RST_UNDER_VOLTAGE, ot: RST_OVER_TEMP,
      ut: RST_UNDER_TEMP, ps: RST_PARALLEL, soclo: RST_SOC_LOW,
      sochi: RST_SOC_HIGH, ns: RST_SERIES
   };

   localparam mod_type MOD_CLEAR = '{
      sum: '0, low: '1, high: '0, temp_hi: {1'b1, {(TEMP_W-1){1'b0}}},
      temp_lo: {1'b0, {(TEMP_W-1){1'b1}}}, flags: '0, cells: '0
   };

   // The all-ones value marks that no nonzero cell was seen.
   function automatic logic [CELL_W-1:0] shown_low(input logic [CELL_W-1:0] v);
      return (v == '1) ? '0 : v;
   endfunction

   logic [1:0]                 cmd_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   cfg_type                    cfg_ff, cfg_in;
   mod_type                    mod_ff, mod_in;
   pack_type                   pack_ff, pack_in;
   logic [PSUM_W-1:0]          pv_ff, pv_in;
   logic [30:0]                pv100_ff, pv100_in;
   logic [PSUM_W-1:0]          lons_ff, lons_in;
   logic [PSUM_W-1:0]          den_ff, den_in;
   logic [30:0]                lons100_ff, lons100_in;
   logic [DIV_N_W-1:0]         num_ff, num_in;
   logic                       soc_ok_ff, soc_ok_in;
   logic [SOC_W-1:0]           soc_ff, soc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_data_type               rsp_ff, rsp_in;

   logic [CELL_W-1:0]          cell_mv;
   logic [MSUM_W:0]            msum_wide;
   logic [MSUM_W-1:0]          msum_sat;
   logic signed [TEMP_W-1:0]   temp_sat;
   logic signed [TEMP_W-1:0]   ot_ext;
   logic signed [TEMP_W-1:0]   ut_ext;
   logic [FLAG_W-1:0]          close_flags;
   logic [PSUM_W:0]            psum_wide;
   logic [PS_W-1:0]            ps_eff;
   logic [PSUM_W-1:0]          new_lowest;
   logic [PSUM_W-1:0]          new_highest;
   logic [CELL_W-1:0]          soc_span;
   logic                       out_free;
   logic                       div_start;
   logic [DIV_N_W-1:0]         div_dividend;
   logic [DIV_D_W-1:0]         div_divisor;
   logic                       div_busy;
   logic [DIV_N_W-1:0]         div_quo;

   // Cell value saturated to the unsigned range and added with saturation.
   assign cell_mv   = sample_ff[SAMPLE_W-1] ? '0 : sample_ff[CELL_W-1:0];
   assign msum_wide = {1'b0, mod_ff.sum} + (MSUM_W+1)'(cell_mv);
   assign msum_sat  = msum_wide[MSUM_W] ? '1 : msum_wide[MSUM_W-1:0];

   // Temperature saturated to sixteen signed bits.
   always_comb begin
      case (sample_ff[SAMPLE_W-1:SAMPLE_W-2])
         2'b01:   temp_sat = {1'b0, {(TEMP_W-1){1'b1}}};
         2'b10:   temp_sat = {1'b1, {(TEMP_W-1){1'b0}}};
         default: temp_sat = sample_ff[TEMP_W-1:0];
      endcase
   end

   // Module temperature checks and the pack sum at module close.
   assign ot_ext = {{(TEMP_W-TLIM_W){cfg_ff.ot[TLIM_W-1]}}, cfg_ff.ot};
   assign ut_ext = {{(TEMP_W-TLIM_W){cfg_ff.ut[TLIM_W-1]}}, cfg_ff.ut};
   always_comb begin
      close_flags          = mod_ff.flags;
      close_flags[FLAG_OT] = mod_ff.flags[FLAG_OT] | (mod_ff.temp_hi > ot_ext);
      close_flags[FLAG_UT] = mod_ff.flags[FLAG_UT] | (mod_ff.temp_lo < ut_ext);
   end
   assign psum_wide = {1'b0, pack_ff.sum} + (PSUM_W+1)'(mod_ff.sum);

   // Lifetime pack extremes as they stand after this scan.
   assign new_highest = (pv_ff > pack_ff.highest) ? pv_ff : pack_ff.highest;
   assign new_lowest  = (pv_ff != '0 && pv_ff < pack_ff.lowest) ? pv_ff : pack_ff.lowest;

   assign ps_eff   = (cfg_ff.ps == '0) ? PS_W'(1) : cfg_ff.ps;
   assign soc_span = cfg_ff.sochi - cfg_ff.soclo;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Settings written from the register port.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OVER_VOLTAGE:  cfg_in.ov    = csr_wdata;
            CSR_UNDER_VOLTAGE: cfg_in.uv    = csr_wdata;
            CSR_OVER_TEMP:     cfg_in.ot    = csr_wdata[TLIM_W-1:0];
            CSR_UNDER_TEMP:    cfg_in.ut    = csr_wdata[TLIM_W-1:0];
            CSR_PARALLEL:      cfg_in.ps    = csr_wdata[PS_W-1:0];
            CSR_SOC_LOW:       cfg_in.soclo = csr_wdata;
            CSR_SOC_HIGH:      cfg_in.sochi = csr_wdata;
            CSR_SERIES:        cfg_in.ns    = csr_wdata[NS_W-1:0];
            default: ;
         endcase
      end
   end

   // Module and pack accumulators.
   always_comb begin
      mod_in  = mod_ff;
      pack_in = pack_ff;
      if (cmd.exec_cell && mod_ff.cells != CC_W'(CELLS_PER_MODULE)) begin
         mod_in.cells = mod_ff.cells + CC_W'(1);
         mod_in.sum   = msum_sat;
         if (cell_mv != '0 && cell_mv < mod_ff.low) begin
            mod_in.low = cell_mv;
         end
         if (cell_mv > mod_ff.high) begin
            mod_in.high = cell_mv;
         end
         if (cell_mv > CELL_FLOOR_MV) begin
            if (cell_mv > cfg_ff.ov) mod_in.flags[FLAG_OV] = 1'b1;
            if (cell_mv < cfg_ff.uv) mod_in.flags[FLAG_UV] = 1'b1;
         end
      end
      if (cmd.exec_temp) begin
         if (temp_sat > mod_ff.temp_hi) mod_in.temp_hi = temp_sat;
         if (temp_sat < mod_ff.temp_lo) mod_in.temp_lo = temp_sat;
      end
      if (cmd.module_close) begin
         pack_in.seen  = pack_ff.seen + MS_W'(1);
         pack_in.sum   = psum_wide[PSUM_W] ? '1 : psum_wide[PSUM_W-1:0];
         pack_in.flags = pack_ff.flags | close_flags;
         if (mod_ff.low < pack_ff.low) pack_in.low = mod_ff.low;
         if (mod_ff.high > pack_ff.high) pack_in.high = mod_ff.high;
      end
      if (cmd.pack_close) begin
         pack_in.sum     = '0;
         pack_in.low     = '1;
         pack_in.high    = '0;
         pack_in.flags   = '0;
         pack_in.seen    = '0;
         pack_in.lowest  = new_lowest;
         pack_in.highest = new_highest;
      end
      if (cmd.module_close || cmd.module_drop || cmd.pack_close) begin
         mod_in = MOD_CLEAR;
      end
   end

   // State of charge: products, then difference, then the shared divider.
   always_comb begin
      pv_in      = pv_ff;
      pv100_in   = pv100_ff;
      lons_in    = lons_ff;
      den_in     = den_ff;
      lons100_in = lons100_ff;
      num_in     = num_ff;
      soc_ok_in  = soc_ok_ff;
      soc_in     = soc_ff;
      if (cmd.pv_take) begin
         pv_in = div_quo[PSUM_W-1:0];
      end
      if (cmd.mul1) begin
         pv100_in  = pv_ff * PCT_SCALE;
         lons_in   = cfg_ff.soclo * cfg_ff.ns;
         den_in    = soc_span * cfg_ff.ns;
         soc_ok_in = (cfg_ff.ns != '0) && (cfg_ff.sochi > cfg_ff.soclo);
      end
      if (cmd.mul2) begin
         lons100_in = lons_ff * PCT_SCALE;
      end
      if (cmd.sub) begin
         num_in = {1'b0, pv100_ff} - {1'b0, lons100_ff};
      end
      if (cmd.soc_take) begin
         soc_in = (div_quo > DIV_N_W'(PCT_SCALE)) ? PCT_SCALE : div_quo[SOC_W-1:0];
      end
      if (cmd.soc_zero) begin
         soc_in = '0;
      end
   end

   // The divider serves the pack voltage first and the charge figure second.
   assign div_start    = cmd.pv_start || cmd.soc_start;
   assign div_dividend = cmd.pv_start ? DIV_N_W'(pack_ff.sum) : num_ff;
   assign div_divisor  = cmd.pv_start ? DIV_D_W'(ps_eff) : den_ff;

   bpcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Report register: a beat waits here while new items keep arriving.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.module_close) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{
            report_kind: KIND_MODULE, voltage_mv: PSUM_W'(mod_ff.sum),
            low_cell_mv: shown_low(mod_ff.low), high_cell_mv: mod_ff.high,
            over_voltage: close_flags[FLAG_OV], under_voltage: close_flags[FLAG_UV],
            over_temp: close_flags[FLAG_OT], under_temp: close_flags[FLAG_UT],
            module_count: '0, soc_percent: '0, lowest_pack_mv: '0,
            highest_pack_mv: '0
         };
      end
      if (cmd.pack_close) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{
            report_kind: KIND_PACK, voltage_mv: pv_ff,
            low_cell_mv: shown_low(pack_ff.low), high_cell_mv: pack_ff.high,
            over_voltage: pack_ff.flags[FLAG_OV], under_voltage: pack_ff.flags[FLAG_UV],
            over_temp: pack_ff.flags[FLAG_OT], under_temp: pack_ff.flags[FLAG_UT],
            module_count: COUNT_W'(pack_ff.seen), soc_percent: soc_ff,
            lowest_pack_mv: new_lowest, highest_pack_mv: new_highest
         };
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         mod_ff       <= MOD_CLEAR;
         pack_ff      <= '{sum: '0, low: '1, high: '0, flags: '0, seen: '0,
                           lowest: '1, highest: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         mod_ff       <= mod_in;
         pack_ff      <= pack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_item) begin
         cmd_ff    <= req_cmd;
         sample_ff <= req_sample;
      end
      pv_ff      <= pv_in;
      pv100_ff   <= pv100_in;
      lons_ff    <= lons_in;
      den_ff     <= den_in;
      lons100_ff <= lons100_in;
      num_ff     <= num_in;
      soc_ok_ff  <= soc_ok_in;
      soc_ff     <= soc_in;
      rsp_ff     <= rsp_in;
   end

   // Status toward the controller.
   assign sts.cmd       = cmd_ff;
   assign sts.pack_full = pack_ff.seen == MS_W'(MAX_MODULES);
   assign sts.out_free  = out_free;
   assign sts.div_busy  = div_busy;
   assign sts.soc_go    = soc_ok_ff && !num_ff[DIV_N_W-1] && (num_ff != '0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The counts never pass their limits.
   a_modules_bounded: assert property (@(posedge clock) disable iff (reset)
      pack_ff.seen <= MS_W'(MAX_MODULES))
      else $error("module count passed its limit");

   a_cells_bounded: assert property (@(posedge clock) disable iff (reset)
      mod_ff.cells <= CC_W'(CELLS_PER_MODULE))
      else $error("cell count passed its limit");

   // A report is written only into a free report register.
   a_report_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.module_close || cmd.pack_close) |-> out_free)
      else $error("report written over a waiting beat");

   // The divider is never restarted while it runs.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // Lowest cell trackers only ever take nonzero values.
   a_low_nonzero: assert property (@(posedge clock) disable iff (reset)
      (mod_ff.low != '0) && (pack_ff.low != '0))
      else $error("lowest cell tracker holds zero");

endmodule

@@ rtl/bpcm_ctrl.sv @@
// Controller of the pack monitor: takes one item at a time and sequences its
// accumulation or the pack report steps. Depends on bpcm_pkg.
module bpcm_ctrl import bpcm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (sts.cmd)
               CMD_CELL: begin
                  cmd.exec_cell = 1'b1;
                  state_in      = ST_IDLE;
               end
               CMD_TEMP: begin
                  cmd.exec_temp = 1'b1;
                  state_in      = ST_IDLE;
               end
               CMD_MODULE: begin
                  if (sts.pack_full) begin
                     cmd.module_drop = 1'b1;
                     state_in        = ST_IDLE;
                  end else if (sts.out_free) begin
                     cmd.module_close = 1'b1;
                     state_in         = ST_IDLE;
                  end
               end
               default: begin
                  cmd.pv_start = 1'b1;
                  state_in     = ST_PV_WAIT;
               end
            endcase
         end
         ST_PV_WAIT: begin
            if (!sts.div_busy) begin
               cmd.pv_take = 1'b1;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_SOC_CHK;
         end
         ST_SOC_CHK: begin
            if (sts.soc_go) begin
               cmd.soc_start = 1'b1;
               state_in      = ST_SOC_WAIT;
            end else begin
               cmd.soc_zero = 1'b1;
               state_in     = ST_PACK_OUT;
            end
         end
         ST_SOC_WAIT: begin
            if (!sts.div_busy) begin
               cmd.soc_take = 1'b1;
               state_in     = ST_PACK_OUT;
            end
         end
         ST_PACK_OUT: begin
            if (sts.out_free) begin
               cmd.pack_close = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
